### rtl/core/ftpd_pkg.sv
// ----------------------------------------------------------------------------
// ftpd_pkg
// Shared widths, register indexes, sequencer states and the request and
// response bundles of the serial divider for the freeze/thaw pulse detector.
// ----------------------------------------------------------------------------
package ftpd_pkg;

  localparam int unsigned DaysW    = 9;
  localparam int unsigned FddW     = 20;
  localparam int unsigned SnowW    = 16;
  localparam int unsigned TempW    = 12;
  localparam int unsigned LevelW   = 17;
  localparam int unsigned OptW     = 2;
  localparam int unsigned WarmW    = 4;
  localparam int unsigned MeltSumW = 18;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned ProdW    = DaysW + FddW;      // product of days and sum
  localparam int unsigned DivNumW  = ProdW + 2;         // 2*num + den
  localparam int unsigned DivDenW  = FddW + 1;          // 2*den
  localparam int unsigned QuotW    = DaysW;             // quotient never exceeds the day count
  localparam int unsigned CntW     = 4;

  localparam logic [WarmW-1:0] SpringWarmDays = WarmW'(14);
  localparam logic [WarmW-1:0] WarmDaysMax    = '1;
  localparam logic [FddW-1:0]  FddMax         = '1;
  localparam logic [OptW-1:0]  OptReset       = OptW'(3);

  localparam logic [CfgIdxW-1:0] CFG_PULSE_MAX_DAYS   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_SNOW_ARM_DEPTH   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_SNOW_START_LEVEL = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_FDD_MINIMUM      = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CFG_FDD_FULL_LENGTH  = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CFG_TRIGGER_OPTIONS  = CfgIdxW'(5);

  localparam int unsigned OptNeedFrozen = 0;
  localparam int unsigned OptClearAtEnd = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } ftpd_state_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } ftpd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quotient;
  } ftpd_div_rsp_t;

endpackage

### rtl/core/ftpd_if.sv
// ----------------------------------------------------------------------------
// ftpd channel interfaces
// Valid/ready channels for the daily sample and for the daily result.
// ----------------------------------------------------------------------------
interface ftpd_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ftpd_pkg::SnowW-1:0]    snow_depth;
  logic        [ftpd_pkg::SnowW-1:0]    melt_today;
  logic signed [ftpd_pkg::TempW-1:0]    surface_temp;
  logic signed [ftpd_pkg::TempW-1:0]    subsoil_temp_a;
  logic signed [ftpd_pkg::TempW-1:0]    subsoil_temp_b;
  logic signed [ftpd_pkg::TempW-1:0]    trigger_temp;

  modport source (output valid, snow_depth, melt_today, surface_temp,
                  subsoil_temp_a, subsoil_temp_b, trigger_temp, input ready);
  modport sink   (input valid, snow_depth, melt_today, surface_temp,
                  subsoil_temp_a, subsoil_temp_b, trigger_temp, output ready);
endinterface

interface ftpd_result_if;
  logic                          valid;
  logic                          ready;
  logic                          pulse_active;
  logic [ftpd_pkg::DaysW-1:0]    days_left;
  logic [ftpd_pkg::FddW-1:0]     fdd_total;
  logic                          armed;

  modport source (output valid, pulse_active, days_left, fdd_total, armed,
                  input ready);
  modport sink   (input valid, pulse_active, days_left, fdd_total, armed,
                  output ready);
endinterface

### rtl/core/ftpd_divider.sv
// ----------------------------------------------------------------------------
// ftpd_divider
// Restoring divider, one quotient bit per cycle, for a quotient known to fit
// in QuotW bits. Used for the rounded pulse length interpolation.
// ----------------------------------------------------------------------------
module ftpd_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  ftpd_pkg::ftpd_div_req_t req,
  output ftpd_pkg::ftpd_div_rsp_t rsp
);

  logic [ftpd_pkg::DivNumW-1:0] rem;
  logic [ftpd_pkg::DivNumW-1:0] dsh;
  logic [ftpd_pkg::QuotW-1:0]   quot;
  logic [ftpd_pkg::CntW-1:0]    cnt;
  logic                         done;
  logic                         fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= ftpd_pkg::CntW'(ftpd_pkg::QuotW);
      end else if (cnt != '0) begin
        cnt <= cnt - ftpd_pkg::CntW'(1);
        if (cnt == ftpd_pkg::CntW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      dsh  <= ftpd_pkg::DivNumW'(req.divisor) << (ftpd_pkg::QuotW - 1);
      quot <= '0;
    end else if (cnt != '0) begin
      // trial subtract, keep the remainder when it goes negative
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[ftpd_pkg::QuotW-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

### rtl/core/freeze_thaw_pulse_detector_unit.sv
// ----------------------------------------------------------------------------
// freeze_thaw_pulse_detector_unit
// Daily freeze/thaw pulse detector: degree-day sum, snow arming, spring
// reset and pulse start with a rounded interpolated pulse length.
//
//   channel   dir  handshake          contents
//   sample    in   valid/ready        snow, melt, four soil temperatures
//   result    out  valid/ready        pulse flag, days left, sum, armed
//   cfg       in   cfg_write          cfg_index, cfg_data (no read-back)
//
// A result goes into the output register after the sequencer passes from idle
// through update and, unless pulse_max_days is zero, start and, when the pulse
// length is interpolated, multiply, load and the serial divider steps, to done.
// Sample ready is high only while the sequencer idles, so a sample transfers
// only once the result of the previous sample has been registered.
// A result waits in its output register; a new sample may transfer meanwhile,
// and its result is held back until the previous one has gone out.
// Reset (rst, synchronous) clears the sequencer, configuration, detector state,
// divider counter and output valid flag; trigger_options resets to 3.
// ----------------------------------------------------------------------------
module freeze_thaw_pulse_detector_unit (
  input  logic                               clk,
  input  logic                               rst,
  ftpd_sample_if.sink                        sample,
  ftpd_result_if.source                      result,
  input  logic                               cfg_write,
  input  logic [ftpd_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [ftpd_pkg::CfgDataW-1:0]      cfg_data
);

  // configuration
  logic        [ftpd_pkg::DaysW-1:0]  pulse_max_days;
  logic        [ftpd_pkg::SnowW-1:0]  snow_arm_depth;
  logic signed [ftpd_pkg::LevelW-1:0] snow_start_level;
  logic        [ftpd_pkg::FddW-1:0]   fdd_minimum;
  logic        [ftpd_pkg::FddW-1:0]   fdd_full_length;
  logic        [ftpd_pkg::OptW-1:0]   trigger_options;

  // detector state
  logic [ftpd_pkg::DaysW-1:0] pulse_days;
  logic                       snow_armed;
  logic [ftpd_pkg::FddW-1:0]  fdd_sum;
  logic                       surface_froze;
  logic [ftpd_pkg::WarmW-1:0] warm_days;
  logic [ftpd_pkg::SnowW-1:0] melt_hist0;
  logic [ftpd_pkg::SnowW-1:0] melt_hist1;

  // held sample
  logic        [ftpd_pkg::SnowW-1:0] snow;
  logic        [ftpd_pkg::SnowW-1:0] melt;
  logic signed [ftpd_pkg::TempW-1:0] surf;
  logic signed [ftpd_pkg::TempW-1:0] sub_a;
  logic signed [ftpd_pkg::TempW-1:0] sub_b;
  logic signed [ftpd_pkg::TempW-1:0] trig;
  logic        [ftpd_pkg::MeltSumW-1:0] melt3;

  // interpolation operands
  logic [ftpd_pkg::FddW-1:0]  den;
  logic [ftpd_pkg::FddW-1:0]  diff;
  logic [ftpd_pkg::ProdW-1:0] prod;

  // output register
  logic                       out_valid;
  logic                       out_active;
  logic [ftpd_pkg::DaysW-1:0] out_days;
  logic [ftpd_pkg::FddW-1:0]  out_fdd;
  logic                       out_armed;

  ftpd_pkg::ftpd_state_t   state;
  ftpd_pkg::ftpd_state_t   state_next;
  ftpd_pkg::ftpd_div_req_t div_req;
  ftpd_pkg::ftpd_div_rsp_t div_rsp;

  logic sample_xfer;
  logic result_xfer;
  logic out_free;

  assign sample_xfer = sample.valid && sample.ready;
  assign result_xfer = out_valid && result.ready;
  assign out_free    = !out_valid || result.ready;

  // --------------------------------------------------------------------------
  // daily update: spring reset, pulse end, melt history, degree days, arming
  // --------------------------------------------------------------------------
  logic                       thawed;
  logic                       fdd_trigger;
  logic                       surf_warm;
  logic                       spring;
  logic                       froze_1;
  logic [ftpd_pkg::WarmW-1:0] warm_1;
  logic [ftpd_pkg::DaysW-1:0] days_1;
  logic [ftpd_pkg::FddW-1:0]  fdd_1;
  logic                       armed_1;
  logic [ftpd_pkg::TempW:0]   surf_cold;
  logic [ftpd_pkg::FddW:0]    fdd_add;
  logic [ftpd_pkg::FddW-1:0]  fdd_2;
  logic                       armed_2;
  logic                       snow_deep;
  logic [ftpd_pkg::MeltSumW-1:0] melt3_now;

  always_comb begin
    thawed      = (sub_a > 0) && (sub_b > 0);
    fdd_trigger = (snow_arm_depth == '0) && (fdd_minimum != '0);
    surf_warm   = surf > 0;
    snow_deep   = snow > snow_arm_depth;

    froze_1 = surface_froze || !thawed;
    if (!thawed) begin
      warm_1 = '0;
    end else if (warm_days != ftpd_pkg::WarmDaysMax) begin
      warm_1 = warm_days + ftpd_pkg::WarmW'(1);
    end else begin
      warm_1 = warm_days;
    end

    spring = (snow_armed && surf_warm && (snow == '0)) ||
             ((fdd_minimum != '0) && (fdd_sum != '0) &&
              (warm_1 >= ftpd_pkg::SpringWarmDays));

    days_1  = pulse_days;
    fdd_1   = fdd_sum;
    armed_1 = snow_armed;
    if ((pulse_days == ftpd_pkg::DaysW'(1)) || spring) begin
      if (spring || ((pulse_days != '0) && trigger_options[ftpd_pkg::OptClearAtEnd])) begin
        fdd_1 = '0;
      end
      if (spring) begin
        froze_1 = 1'b0;
      end
      days_1  = '0;
      armed_1 = 1'b0;
    end else if (pulse_days != '0) begin
      // abort on fresh snow or, in degree-day trigger mode, on a refreeze of the subsoil
      if ((snow_deep && (snow_start_level > 0)) || (fdd_trigger && !thawed)) begin
        days_1 = '0;
      end else begin
        days_1 = pulse_days - ftpd_pkg::DaysW'(1);
      end
    end

    melt3_now = ftpd_pkg::MeltSumW'(melt) + ftpd_pkg::MeltSumW'(melt_hist0) +
                ftpd_pkg::MeltSumW'(melt_hist1);

    surf_cold = (ftpd_pkg::TempW + 1)'(0) - {surf[ftpd_pkg::TempW-1], surf};
    fdd_add   = {1'b0, fdd_1} + (ftpd_pkg::FddW + 1)'(surf_cold);
    if (surf_warm) begin
      fdd_2 = fdd_1;
    end else if (fdd_add[ftpd_pkg::FddW]) begin
      fdd_2 = ftpd_pkg::FddMax;
    end else begin
      fdd_2 = fdd_add[ftpd_pkg::FddW-1:0];
    end

    armed_2 = armed_1 || (snow_deep && (snow_arm_depth != '0));
  end

  // --------------------------------------------------------------------------
  // pulse start decision, on the updated state
  // --------------------------------------------------------------------------
  logic                        start_go;
  logic                        interp;
  logic                        snow_go;
  logic                        fdd_go;
  logic [ftpd_pkg::LevelW-1:0] level_mag;

  always_comb begin
    level_mag = ftpd_pkg::LevelW'(0) - snow_start_level;
    snow_go   = snow_armed &&
                (($signed({1'b0, snow}) <= snow_start_level) ||
                 (snow_start_level[ftpd_pkg::LevelW-1] &&
                  (melt3 > ftpd_pkg::MeltSumW'(level_mag))));
    fdd_go    = (snow_arm_depth == '0) && (fdd_minimum != '0) && (trig > 0) &&
                (surface_froze || !trigger_options[ftpd_pkg::OptNeedFrozen]);
    start_go  = (pulse_days == '0) && (fdd_sum >= fdd_minimum) && (snow_go || fdd_go);
    interp    = (fdd_full_length > fdd_minimum) && (fdd_sum < fdd_full_length);
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    sample.ready     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {prod, 1'b0} + ftpd_pkg::DivNumW'(den);
    div_req.divisor  = {den, 1'b0};
    unique case (state)
      ftpd_pkg::ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = ftpd_pkg::ST_UPDATE;
        end
      end
      ftpd_pkg::ST_UPDATE: begin
        state_next = (pulse_max_days == '0) ? ftpd_pkg::ST_DONE : ftpd_pkg::ST_START;
      end
      ftpd_pkg::ST_START: begin
        state_next = (start_go && interp) ? ftpd_pkg::ST_MUL : ftpd_pkg::ST_DONE;
      end
      ftpd_pkg::ST_MUL: begin
        state_next = ftpd_pkg::ST_LOAD;
      end
      ftpd_pkg::ST_LOAD: begin
        div_req.start = 1'b1;
        state_next    = ftpd_pkg::ST_DIV;
      end
      ftpd_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ftpd_pkg::ST_DONE;
        end
      end
      ftpd_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ftpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ftpd_pkg::ST_IDLE;
      end
    endcase
  end

  ftpd_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_max_days   <= '0;
      snow_arm_depth   <= '0;
      snow_start_level <= '0;
      fdd_minimum      <= '0;
      fdd_full_length  <= '0;
      trigger_options  <= ftpd_pkg::OptReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ftpd_pkg::CFG_PULSE_MAX_DAYS:   pulse_max_days   <= cfg_data[ftpd_pkg::DaysW-1:0];
        ftpd_pkg::CFG_SNOW_ARM_DEPTH:   snow_arm_depth   <= cfg_data[ftpd_pkg::SnowW-1:0];
        ftpd_pkg::CFG_SNOW_START_LEVEL: snow_start_level <= cfg_data[ftpd_pkg::LevelW-1:0];
        ftpd_pkg::CFG_FDD_MINIMUM:      fdd_minimum      <= cfg_data[ftpd_pkg::FddW-1:0];
        ftpd_pkg::CFG_FDD_FULL_LENGTH:  fdd_full_length  <= cfg_data[ftpd_pkg::FddW-1:0];
        ftpd_pkg::CFG_TRIGGER_OPTIONS:  trigger_options  <= cfg_data[ftpd_pkg::OptW-1:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // detector state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_days    <= '0;
      snow_armed    <= 1'b0;
      fdd_sum       <= '0;
      surface_froze <= 1'b0;
      warm_days     <= '0;
      melt_hist0    <= '0;
      melt_hist1    <= '0;
    end else begin
      case (state)
        ftpd_pkg::ST_UPDATE: begin
          if (pulse_max_days != '0) begin
            pulse_days    <= days_1;
            snow_armed    <= armed_2;
            fdd_sum       <= fdd_2;
            surface_froze <= froze_1;
            warm_days     <= warm_1;
            melt_hist1    <= melt_hist0;
            melt_hist0    <= melt;
          end
        end
        ftpd_pkg::ST_START: begin
          if (start_go) begin
            surface_froze <= 1'b0;
            if (!interp) begin
              pulse_days <= pulse_max_days;
            end
          end
        end
        ftpd_pkg::ST_DIV: begin
          if (div_rsp.done) begin
            pulse_days <= div_rsp.quotient;
          end
        end
        default: begin
          // hold
        end
      endcase
    end
  end

  // held sample and interpolation operands
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      snow  <= sample.snow_depth;
      melt  <= sample.melt_today;
      surf  <= sample.surface_temp;
      sub_a <= sample.subsoil_temp_a;
      sub_b <= sample.subsoil_temp_b;
      trig  <= sample.trigger_temp;
    end
    if (state == ftpd_pkg::ST_UPDATE) begin
      melt3 <= melt3_now;
    end
    if (state == ftpd_pkg::ST_START) begin
      den  <= fdd_full_length - fdd_minimum;
      diff <= fdd_sum - fdd_minimum;
    end
    if (state == ftpd_pkg::ST_MUL) begin
      prod <= ftpd_pkg::ProdW'(pulse_max_days) * ftpd_pkg::ProdW'(diff);
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ftpd_pkg::ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (result_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ftpd_pkg::ST_DONE) && out_free) begin
      out_active <= (pulse_days != '0);
      out_days   <= pulse_days;
      out_fdd    <= fdd_sum;
      out_armed  <= snow_armed;
    end
  end

  assign result.valid        = out_valid;
  assign result.pulse_active = out_active;
  assign result.days_left    = out_days;
  assign result.fdd_total    = out_fdd;
  assign result.armed        = out_armed;

endmodule

### tb/freeze_thaw_pulse_detector_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// freeze_thaw_pulse_detector_unit_tb
// Drives daily samples through the freeze/thaw pulse detector under random
// sender bursts and receiver stalls. A built-in day-by-day forecast of the
// detector state predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------
module freeze_thaw_pulse_detector_unit_tb;
  import ftpd_pkg::*;

  typedef struct {
    logic        [SnowW-1:0] snow_depth;
    logic        [SnowW-1:0] melt_today;
    logic signed [TempW-1:0] surface_temp;
    logic signed [TempW-1:0] subsoil_temp_a;
    logic signed [TempW-1:0] subsoil_temp_b;
    logic signed [TempW-1:0] trigger_temp;
  } day_sample_t;

  typedef struct {
    logic             pulse_active;
    logic [DaysW-1:0] days_left;
    logic [FddW-1:0]  fdd_total;
    logic             armed;
  } day_report_t;

  typedef struct {
    int pulse_max;
    int arm_depth;
    int start_level;
    int fdd_min;
    int fdd_full;
    int options;
  } pulse_setting_t;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_t;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = CfgIdxW'(7);
  localparam int FddCeil      = int'(FddMax);
  localparam int WarmCap      = int'(WarmDaysMax);
  localparam int SpringDays   = int'(SpringWarmDays);
  localparam int SettleCycles = 20;

  // Day-by-day forecast of the detector and the queue of reports it owes.
  class pulse_ledger;
    int pulse_max, arm_depth, start_level, fdd_min, fdd_full, options;
    int days_to_go, frost_sum, warm_run;
    bit is_armed, surface_frozen;
    int melt_prev [2];
    day_report_t pending_reports [$];
    int mismatches;

    function new();
      pulse_max      = 0;
      arm_depth      = 0;
      start_level    = 0;
      fdd_min        = 0;
      fdd_full       = 0;
      options        = int'(OptReset);
      days_to_go     = 0;
      frost_sum      = 0;
      warm_run       = 0;
      is_armed       = 1'b0;
      surface_frozen = 1'b0;
      melt_prev[0]   = 0;
      melt_prev[1]   = 0;
      mismatches     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_PULSE_MAX_DAYS:   pulse_max   = int'(data[DaysW-1:0]);
        CFG_SNOW_ARM_DEPTH:   arm_depth   = int'(data[SnowW-1:0]);
        CFG_SNOW_START_LEVEL: start_level = int'($signed(data[LevelW-1:0]));
        CFG_FDD_MINIMUM:      fdd_min     = int'(data[FddW-1:0]);
        CFG_FDD_FULL_LENGTH:  fdd_full    = int'(data[FddW-1:0]);
        CFG_TRIGGER_OPTIONS:  options     = int'(data[OptW-1:0]);
        default: ;
      endcase
    endfunction

    function day_report_t advance_day(day_sample_t d);
      int snow, melt, surf, sub_a, sub_b, trig, melt3, raised;
      bit thawed, fdd_trigger, spring, snow_go, fdd_go;
      longint num, den;
      day_report_t r;
      if (pulse_max != 0) begin
        snow  = int'(d.snow_depth);
        melt  = int'(d.melt_today);
        surf  = int'(d.surface_temp);
        sub_a = int'(d.subsoil_temp_a);
        sub_b = int'(d.subsoil_temp_b);
        trig  = int'(d.trigger_temp);
        thawed      = sub_a > 0 && sub_b > 0;
        fdd_trigger = arm_depth == 0 && fdd_min > 0;

        if (!thawed) surface_frozen = 1'b1;
        if (thawed) begin
          if (warm_run < WarmCap) warm_run++;
        end else begin
          warm_run = 0;
        end

        spring = (is_armed && surf > 0 && snow == 0) ||
                 (fdd_min != 0 && frost_sum > 0 && warm_run >= SpringDays);

        // end the pulse on its last day or on spring; abort on fresh snow or refreezing
        if (days_to_go == 1 || spring) begin
          if (days_to_go >= 1 && options[OptClearAtEnd]) frost_sum = 0;
          if (spring) begin
            frost_sum      = 0;
            surface_frozen = 1'b0;
          end
          days_to_go = 0;
          is_armed   = 1'b0;
        end else if (days_to_go > 0) begin
          days_to_go--;
          if ((snow > arm_depth && start_level > 0) || (fdd_trigger && !thawed))
            days_to_go = 0;
        end

        melt3        = melt + melt_prev[0] + melt_prev[1];
        melt_prev[1] = melt_prev[0];
        melt_prev[0] = melt;

        if (surf <= 0) begin
          raised    = frost_sum - surf;
          frost_sum = raised > FddCeil ? FddCeil : raised;
        end

        if (snow > arm_depth && arm_depth > 0) is_armed = 1'b1;

        if (days_to_go == 0 && frost_sum >= fdd_min) begin
          snow_go = is_armed &&
                    (snow <= start_level || (start_level < 0 && melt3 > -start_level));
          fdd_go  = fdd_trigger && trig > 0 &&
                    (surface_frozen || !options[OptNeedFrozen]);
          if (snow_go || fdd_go) begin
            if (fdd_full > fdd_min && frost_sum < fdd_full) begin
              num        = longint'(pulse_max) * longint'(frost_sum - fdd_min);
              den        = longint'(fdd_full - fdd_min);
              days_to_go = int'((2 * num + den) / (2 * den));
            end else begin
              days_to_go = pulse_max;
            end
            surface_frozen = 1'b0;
          end
        end
      end
      r.pulse_active = days_to_go > 0;
      r.days_left    = DaysW'(days_to_go);
      r.fdd_total    = FddW'(frost_sum);
      r.armed        = is_armed;
      return r;
    endfunction

    function void log_day(day_sample_t d);
      pending_reports.push_back(advance_day(d));
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void match_report(day_report_t got);
      day_report_t want;
      if (pending_reports.size() == 0) begin
        $error("result transfer with no sample waiting (days_left %0d)", got.days_left);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.pulse_active !== want.pulse_active) begin
        $error("pulse_active: expected %0d, got %0d", want.pulse_active, got.pulse_active);
        mismatches++;
      end
      if (got.days_left !== want.days_left) begin
        $error("days_left: expected %0d, got %0d", want.days_left, got.days_left);
        mismatches++;
      end
      if (got.fdd_total !== want.fdd_total) begin
        $error("fdd_total: expected %0d, got %0d", want.fdd_total, got.fdd_total);
        mismatches++;
      end
      if (got.armed !== want.armed) begin
        $error("armed: expected %0d, got %0d", want.armed, got.armed);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ftpd_sample_if day_in ();
  ftpd_result_if day_out ();

  pulse_ledger ledger = new();
  int burst_left = 0;

  freeze_thaw_pulse_detector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (day_in),
    .result    (day_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic day_sample_t make_day(int snow, int melt, int surf,
                                           int sub_a, int sub_b, int trig);
    day_sample_t d;
    d.snow_depth     = SnowW'(snow);
    d.melt_today     = SnowW'(melt);
    d.surface_temp   = TempW'(surf);
    d.subsoil_temp_a = TempW'(sub_a);
    d.subsoil_temp_b = TempW'(sub_b);
    d.trigger_temp   = TempW'(trig);
    return d;
  endfunction

  function automatic day_sample_t random_day();
    return make_day(pick(0, 65535), pick(0, 65535), pick(-2048, 2047),
                    pick(-2048, 2047), pick(-2048, 2047), pick(-2048, 2047));
  endfunction

  function automatic pulse_setting_t random_setting();
    pulse_setting_t s;
    bit fdd_mode;
    case (pick(0, 9))
      0:       s.pulse_max = 1;
      1:       s.pulse_max = 511;
      2:       s.pulse_max = 365;
      default: s.pulse_max = pick(2, 60);
    endcase
    fdd_mode = pick(0, 2) == 0;
    if (fdd_mode)             s.arm_depth = 0;
    else if (pick(0, 6) == 0) s.arm_depth = 65535;
    else                      s.arm_depth = pick(128, 6000);
    case (pick(0, 9))
      0:       s.start_level = -65535;
      1:       s.start_level = 65535;
      2:       s.start_level = 0;
      3, 4, 5: s.start_level = pick(-3000, -1);
      default: s.start_level = pick(0, s.arm_depth);
    endcase
    if (fdd_mode)             s.fdd_min = pick(1, 15000);
    else if (pick(0, 1) == 0) s.fdd_min = 0;
    else                      s.fdd_min = pick(0, 10000);
    if (pick(0, 19) == 0) s.fdd_min = FddCeil;
    case (pick(0, 19))
      0, 1, 2, 3: s.fdd_full = 0;
      4, 5, 6:    s.fdd_full = FddCeil;
      7, 8, 9:    s.fdd_full = pick(0, s.fdd_min);
      default:    s.fdd_full = pick(s.fdd_min, s.fdd_min + 30000);
    endcase
    if (s.fdd_full > FddCeil) s.fdd_full = FddCeil;
    s.options = pick(0, 3);
    return s;
  endfunction

  // Present one day, hold it until the transfer, then maybe pause the sender.
  task automatic send_day(input day_sample_t d);
    int gap;
    @(negedge clk);
    day_in.valid          = 1'b1;
    day_in.snow_depth     = d.snow_depth;
    day_in.melt_today     = d.melt_today;
    day_in.surface_temp   = d.surface_temp;
    day_in.subsoil_temp_a = d.subsoil_temp_a;
    day_in.subsoil_temp_b = d.subsoil_temp_b;
    day_in.trigger_temp   = d.trigger_temp;
    @(posedge clk);
    while (!day_in.ready) @(posedge clk);
    ledger.log_day(d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = (pick(0, 9) == 0) ? pick(40, 120) : pick(0, 20);
      gap        = (pick(0, 3) == 0) ? pick(1, 40) : pick(1, 12);
      @(negedge clk);
      day_in.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = CfgDataW'(value);
    @(posedge clk);
    ledger.set_reg(idx, CfgDataW'(value));
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic apply_setting(input pulse_setting_t s);
    write_reg(CFG_PULSE_MAX_DAYS, s.pulse_max);
    write_reg(CFG_SNOW_ARM_DEPTH, s.arm_depth);
    write_reg(CFG_SNOW_START_LEVEL, s.start_level);
    write_reg(CFG_FDD_MINIMUM, s.fdd_min);
    write_reg(CFG_FDD_FULL_LENGTH, s.fdd_full);
    write_reg(CFG_TRIGGER_OPTIONS, s.options);
  endtask

  // Drop valid, wait for every owed report, then let the pipeline go quiet.
  task automatic settle();
    @(negedge clk);
    day_in.valid = 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // A deep freeze runs long cold spells toward the sum ceiling; otherwise
  // days follow winter, thaw and summer seasons with bits of noise between.
  task automatic run_phase(input pulse_setting_t s, input int days, input bit deep_freeze);
    int sent, snow, i, len, melt;
    apply_setting(s);
    sent = 0;
    while (sent < days) begin
      if (deep_freeze) begin
        if (pick(0, 19) == 0) send_day(random_day());
        else send_day(make_day(pick(0, 3000), pick(0, 300), pick(-2048, -1980),
                               pick(-300, 60), pick(-300, 60), pick(-100, 100)));
        sent++;
      end else if (pick(0, 6) == 0) begin
        len = pick(1, 5);
        for (i = 0; i < len; i++) send_day(random_day());
        sent += len;
      end else begin
        snow = 0;
        len  = pick(8, 50);
        for (i = 0; i < len; i++) begin
          snow += pick(0, s.arm_depth / 4 + 64);
          if (snow > 65535) snow = 65535;
          send_day(make_day(snow, pick(0, 40), pick(-700, 30), pick(-400, 20),
                            pick(-400, 20), pick(-300, 20)));
        end
        sent += len;
        len = pick(3, 25);
        for (i = 0; i < len; i++) begin
          melt = pick(0, snow / 3 + 150);
          snow = snow > melt ? snow - melt : 0;
          send_day(make_day(snow, melt, pick(-40, 500), pick(-20, 400),
                            pick(-20, 400), pick(-20, 400)));
        end
        sent += len;
        len = pick(0, 20);
        for (i = 0; i < len; i++)
          send_day(make_day(0, 0, pick(1, 800), pick(1, 600), pick(1, 600), pick(-5, 600)));
        sent += len;
      end
    end
    settle();
  endtask

  // Receiver: stall on a changing mix of patterns.
  initial begin : rx_side
    rx_mode_t mode;
    int span, period, hold, tick;
    day_out.ready = 1'b0;
    hold = 0;
    tick = 0;
    forever begin
      mode   = rx_mode_t'(pick(0, 3));
      span   = pick(20, 300);
      period = pick(2, 6);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          RX_STEADY:   day_out.ready = 1'b1;
          RX_COIN:     day_out.ready = pick(0, 1) == 1;
          RX_PERIODIC: day_out.ready = (tick % period) == 0;
          RX_BURSTY: begin
            if (hold > 0) begin
              hold--;
            end else if (day_out.ready) begin
              day_out.ready = 1'b0;
              hold          = pick(10, 40);
            end else begin
              day_out.ready = 1'b1;
              hold          = pick(0, 4);
            end
          end
          default: day_out.ready = 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin : take_result
    day_report_t got;
    if (!rst && day_out.valid && day_out.ready) begin
      got.pulse_active = day_out.pulse_active;
      got.days_left    = day_out.days_left;
      got.fdd_total    = day_out.fdd_total;
      got.armed        = day_out.armed;
      ledger.match_report(got);
    end
  end

  initial begin : watchdog
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    pulse_setting_t s;
    int p;
    day_in.valid          = 1'b0;
    day_in.snow_depth     = '0;
    day_in.melt_today     = '0;
    day_in.surface_temp   = '0;
    day_in.subsoil_temp_a = '0;
    day_in.subsoil_temp_b = '0;
    day_in.trigger_temp   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // disabled out of reset: field extremes must leave the state untouched
    send_day(make_day(65535, 65535, -2048, 2047, -2048, 2047));
    send_day(make_day(0, 0, 2047, -2048, 2047, -2048));
    settle();

    // degree-day trigger, interpolated length, maximum pulse length over 365, thaw test
    s = '{pulse_max: 511, arm_depth: 0, start_level: 0, fdd_min: 1,
          fdd_full: FddCeil, options: 3};
    apply_setting(s);
    write_reg(CFG_SPARE_LO, FddCeil);
    write_reg(CFG_SPARE_HI, 'h5A5A5);
    send_day(make_day(0, 0, -2048, -2048, -2048, 2047));
    send_day(make_day(0, 0, 0, 1, 0, 0));
    send_day(make_day(0, 0, -5, 0, 1, 3));
    send_day(make_day(0, 0, 2047, 1, 1, 1));
    send_day(make_day(0, 0, -1, 2047, 2047, 2047));
    send_day(make_day(0, 0, -2048, -1, -1, -2048));
    settle();

    // freeze with state held, then release
    write_reg(CFG_PULSE_MAX_DAYS, 0);
    send_day(make_day(0, 0, -2048, -2048, -2048, 2047));
    send_day(make_day(65535, 65535, -2048, -2048, -2048, 2047));
    settle();
    write_reg(CFG_PULSE_MAX_DAYS, 511);

    // melt trigger at start level -65535, then spring on bare ground
    s = '{pulse_max: 365, arm_depth: 1000, start_level: -65535, fdd_min: 0,
          fdd_full: 0, options: 0};
    apply_setting(s);
    send_day(make_day(1001, 0, -16, -16, -16, -16));
    send_day(make_day(1001, 65535, -16, -16, -16, -16));
    send_day(make_day(900, 65535, -16, -16, -16, -16));
    send_day(make_day(800, 65535, -16, -16, -16, -16));
    send_day(make_day(0, 0, 16, 16, 16, 16));
    settle();

    // depth trigger at the top start level, abort on deep snow, spring reset
    s = '{pulse_max: 3, arm_depth: 1, start_level: 65535, fdd_min: 0,
          fdd_full: 0, options: 2};
    apply_setting(s);
    send_day(make_day(2, 0, -16, -16, -16, -16));
    send_day(make_day(65535, 10, -16, -16, -16, -16));
    send_day(make_day(0, 0, 16, -16, -16, -16));
    settle();

    // long cold spell: drive the sum into saturation with the top minimum
    s = random_setting();
    s.arm_depth = 0;
    s.fdd_min   = FddCeil;
    s.fdd_full  = FddCeil;
    run_phase(s, 620, 1'b1);

    for (p = 0; p < 6; p++) run_phase(random_setting(), 100, 1'b0);

    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
